// File: rtl/pac_pkg.sv
// Shared types, constants and helper functions for the proximity/light classifier.
`timescale 1ns / 1ps
package pac_pkg;

    localparam int SAMPLE_W      = 16;
    localparam int COUNT_W       = 12;
    localparam int THR_W         = 12;
    localparam int ERR_W         = 13;
    localparam int CFG_DATA_W    = 13;
    localparam int CFG_IDX_W     = 3;
    localparam int LEVEL_W       = 3;
    localparam int LIGHT_VALUE_W = 18;
    localparam int LIGHT_SCALE   = 64;
    localparam int NUM_LEVELS    = 7;

    localparam logic [COUNT_W-1:0] CLAMP_MAX    = 12'hFFF;
    localparam logic [ERR_W-1:0]   ADC_FULL     = 13'd4096;
    localparam logic [ERR_W-1:0]   RANGE_MARGIN = 13'd500;
    localparam logic [ERR_W-1:0]   GATE_LIMIT   = 13'(4096 / 5);

    localparam logic [THR_W-1:0] LOW_NEAR_RST  = 12'd400;
    localparam logic [THR_W-1:0] HIGH_NEAR_RST = 12'd450;
    localparam logic [ERR_W-1:0] ERR_NEAR_RST  = 13'd4096;
    localparam logic [THR_W-1:0] LOW_WIDE_RST  = 12'd10;
    localparam logic [THR_W-1:0] HIGH_WIDE_RST = 12'd12;
    localparam logic [ERR_W-1:0] ERR_WIDE_RST  = 13'd50;

    localparam logic [COUNT_W-1:0] LEVEL_TABLE [NUM_LEVELS] = '{
        12'd5, 12'd20, 12'd32, 12'd64, 12'd256, 12'd640, 12'd1024
    };

    typedef enum logic [2:0] {
        CMD_START     = 3'd0,
        CMD_IR        = 3'd1,
        CMD_PS        = 3'd2,
        CMD_ALS       = 3'd3,
        CMD_PROX_OPEN = 3'd4,
        CMD_LIGHT_OPEN = 3'd5
    } t_cmd;

    typedef enum logic [2:0] {
        ACT_MEASURE_IR  = 3'd0,
        ACT_MEASURE_PS  = 3'd1,
        ACT_REPORT_PROX = 3'd2,
        ACT_DONE        = 3'd3,
        ACT_LIGHT_LEVEL = 3'd4,
        ACT_LIGHT_INVAL = 3'd5,
        ACT_ACK         = 3'd6
    } t_action;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LOW_NEAR  = 3'd0,
        REG_HIGH_NEAR = 3'd1,
        REG_ERR_NEAR  = 3'd2,
        REG_LOW_WIDE  = 3'd3,
        REG_HIGH_WIDE = 3'd4,
        REG_ERR_WIDE  = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [THR_W-1:0] low_near;
        logic [THR_W-1:0] high_near;
        logic [ERR_W-1:0] err_near;
        logic [THR_W-1:0] low_wide;
        logic [THR_W-1:0] high_wide;
        logic [ERR_W-1:0] err_wide;
    } t_thr;

    typedef struct packed {
        logic [2:0]               action;
        logic                     range_sel;
        logic                     is_far;
        logic [LEVEL_W-1:0]       light_level;
        logic [COUNT_W-1:0]       prox_value;
        logic [LIGHT_VALUE_W-1:0] light_value;
    } t_result;

    function automatic logic [COUNT_W-1:0] clamp_sample(input logic [SAMPLE_W-1:0] s);
        logic [COUNT_W-1:0] v;
        v = (s > SAMPLE_W'(CLAMP_MAX)) ? CLAMP_MAX : s[COUNT_W-1:0];
        return v;
    endfunction

    // First table entry above the count wins; at or past the top entry, level 6.
    function automatic logic [LEVEL_W-1:0] light_level_of(input logic [COUNT_W-1:0] c);
        logic [LEVEL_W-1:0] lvl;
        lvl = LEVEL_W'(NUM_LEVELS - 1);
        for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
            if (c < LEVEL_TABLE[i]) begin
                lvl = LEVEL_W'(i);
            end
        end
        return lvl;
    endfunction

endpackage

// File: rtl/pac_cfg_regs.sv
// Threshold register file with a plain write port.
`timescale 1ns / 1ps
module pac_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [pac_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [pac_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output pac_pkg::t_thr                  o_thr
);
    import pac_pkg::*;

    t_thr r_thr;
    t_thr n_thr;

    always_comb begin
        n_thr = r_thr;
        if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_LOW_NEAR:  n_thr.low_near  = i_cfg_data[THR_W-1:0];
                REG_HIGH_NEAR: n_thr.high_near = i_cfg_data[THR_W-1:0];
                REG_ERR_NEAR:  n_thr.err_near  = i_cfg_data[ERR_W-1:0];
                REG_LOW_WIDE:  n_thr.low_wide  = i_cfg_data[THR_W-1:0];
                REG_HIGH_WIDE: n_thr.high_wide = i_cfg_data[THR_W-1:0];
                REG_ERR_WIDE:  n_thr.err_wide  = i_cfg_data[ERR_W-1:0];
                default:       n_thr = r_thr;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr.low_near  <= LOW_NEAR_RST;
            r_thr.high_near <= HIGH_NEAR_RST;
            r_thr.err_near  <= ERR_NEAR_RST;
            r_thr.low_wide  <= LOW_WIDE_RST;
            r_thr.high_wide <= HIGH_WIDE_RST;
            r_thr.err_wide  <= ERR_WIDE_RST;
        end else begin
            r_thr <= n_thr;
        end
    end

    assign o_thr = r_thr;

endmodule

// File: rtl/pac_core.sv
// Sequencer state and per-command classification logic.
`timescale 1ns / 1ps
module pac_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_fire,
    input  logic [2:0]                   i_cmd,
    input  logic [pac_pkg::SAMPLE_W-1:0] i_sample,
    input  pac_pkg::t_thr                i_thr,
    output logic                         o_res_valid,
    output pac_pkg::t_result             o_res
);
    import pac_pkg::*;

    typedef enum logic [1:0] {
        EV_NONE = 2'd0,
        EV_NEAR = 2'd1,
        EV_FAR  = 2'd2
    } t_event;

    logic               r_range;
    logic               r_adjust;
    t_event             r_last_ev;
    logic [COUNT_W-1:0] r_held_ir;
    logic               r_light_first;

    logic               n_range;
    logic               n_adjust;
    t_event             n_last_ev;
    logic [COUNT_W-1:0] n_held_ir;
    logic               n_light_first;

    logic [COUNT_W-1:0] w_s;
    logic [THR_W-1:0]   w_low;
    logic [THR_W-1:0]   w_high;
    logic [ERR_W-1:0]   w_err;
    logic [ERR_W-1:0]   w_head;
    logic [ERR_W-1:0]   w_up;
    logic [ERR_W-1:0]   w_head_n;
    logic [ERR_W-1:0]   w_gate;
    logic [ERR_W-1:0]   w_down;
    logic [COUNT_W-1:0] w_diff;
    t_event             w_ev;
    logic [LIGHT_VALUE_W-1:0] w_lv;

    assign w_s    = clamp_sample(i_sample);
    assign w_low  = r_range ? i_thr.low_wide  : i_thr.low_near;
    assign w_high = r_range ? i_thr.high_wide : i_thr.high_near;
    assign w_err  = r_range ? i_thr.err_wide  : i_thr.err_near;

    // Range switching limits; every subtraction floors at zero.
    assign w_head   = ADC_FULL - {1'b0, w_high};
    assign w_up     = (w_head > RANGE_MARGIN) ? (w_head - RANGE_MARGIN) : '0;
    assign w_head_n = ADC_FULL - {1'b0, i_thr.high_near};
    assign w_gate   = (w_head_n > GATE_LIMIT) ? (w_head_n - GATE_LIMIT) : '0;
    assign w_down   = r_range ? (w_gate >> 2) : '0;

    assign w_diff = w_s - r_held_ir;
    assign w_lv   = r_range ? LIGHT_VALUE_W'(LIGHT_VALUE_W'(r_held_ir) * LIGHT_SCALE)
                            : LIGHT_VALUE_W'(r_held_ir);

    always_comb begin
        w_ev = EV_NONE;
        if (w_s >= r_held_ir) begin
            if ({1'b0, w_diff} > w_err) begin
                w_ev = EV_NONE;
            end else if (w_diff > w_high) begin
                w_ev = EV_NEAR;
            end else if (w_diff < w_low) begin
                w_ev = EV_FAR;
            end
        end
    end

    always_comb begin
        n_range       = r_range;
        n_adjust      = r_adjust;
        n_last_ev     = r_last_ev;
        n_held_ir     = r_held_ir;
        n_light_first = r_light_first;
        o_res_valid   = 1'b1;
        o_res         = '0;
        case (i_cmd)
            CMD_START: begin
                n_adjust         = 1'b0;
                o_res.action     = ACT_MEASURE_IR;
                o_res.range_sel  = r_range;
            end
            CMD_IR: begin
                n_held_ir       = w_s;
                o_res.action    = ACT_MEASURE_PS;
                o_res.range_sel = r_range;
                if ({1'b0, w_s} > w_up) begin
                    if (!r_adjust && !r_range) begin
                        n_range         = 1'b1;
                        n_adjust        = 1'b1;
                        o_res.action    = ACT_MEASURE_IR;
                        o_res.range_sel = 1'b1;
                    end
                end else if ({1'b0, w_s} < w_down) begin
                    if (!r_adjust && r_range) begin
                        n_range         = 1'b0;
                        n_adjust        = 1'b1;
                        o_res.action    = ACT_MEASURE_IR;
                        o_res.range_sel = 1'b0;
                    end
                end
            end
            CMD_PS: begin
                o_res.prox_value  = w_s;
                o_res.light_value = w_lv;
                case (w_ev)
                    EV_FAR: begin
                        n_last_ev    = EV_FAR;
                        o_res.action = ACT_REPORT_PROX;
                        o_res.is_far = 1'b1;
                    end
                    EV_NEAR: begin
                        // A first near asks for a fresh measurement before reporting.
                        if (r_last_ev != EV_NEAR) begin
                            n_last_ev       = EV_NEAR;
                            o_res.action    = ACT_MEASURE_IR;
                            o_res.range_sel = r_range;
                        end else begin
                            o_res.action = ACT_REPORT_PROX;
                        end
                    end
                    default: begin
                        n_last_ev    = EV_NONE;
                        o_res.action = ACT_DONE;
                    end
                endcase
            end
            CMD_ALS: begin
                if (r_light_first) begin
                    n_light_first = 1'b0;
                    o_res.action  = ACT_LIGHT_INVAL;
                end else begin
                    o_res.action      = ACT_LIGHT_LEVEL;
                    o_res.light_level = light_level_of(w_s);
                end
            end
            CMD_PROX_OPEN: begin
                n_range      = 1'b0;
                n_adjust     = 1'b0;
                o_res.action = ACT_REPORT_PROX;
                o_res.is_far = 1'b1;
            end
            CMD_LIGHT_OPEN: begin
                n_light_first = 1'b1;
                o_res.action  = ACT_ACK;
            end
            default: begin
                o_res_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range       <= 1'b0;
            r_adjust      <= 1'b0;
            r_last_ev     <= EV_NONE;
            r_held_ir     <= '0;
            r_light_first <= 1'b1;
        end else if (i_fire) begin
            r_range       <= n_range;
            r_adjust      <= n_adjust;
            r_last_ev     <= n_last_ev;
            r_held_ir     <= n_held_ir;
            r_light_first <= n_light_first;
        end
    end

    // At most one range switch between two start or proximity-open commands.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && r_adjust && i_cmd != CMD_START && i_cmd != CMD_PROX_OPEN
        |=> r_adjust && r_range == $past(r_range))
        else $error("range switched twice in one cycle");

    // A range switch on an IR command always raises the adjust flag.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && (n_range != r_range) && i_cmd == CMD_IR |=> r_adjust)
        else $error("range switch without adjust flag");

    // Illegal commands leave the sequencer state alone.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && !o_res_valid |=> $stable(r_range) && $stable(r_last_ev)
        && $stable(r_held_ir) && $stable(r_light_first))
        else $error("illegal command changed state");

endmodule

// File: rtl/proximity_autorange_classifier.sv
// An accepted transaction passes through the input register, then the result register.
// Throughput: one transaction per cycle while results are taken; the result register
// advances whenever it is empty or being taken, the input register also while it is empty.
// Commands six and seven are consumed without producing a result.
// Reset (i_rst_n low, synchronous) empties both registers, loads the threshold defaults
// and returns the sequencer to the sensitive range with the first light read pending.
`timescale 1ns / 1ps
module proximity_autorange_classifier (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [pac_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [pac_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [15:0]                    s_axis_tdata,  // [15:0] sample
    input  logic [2:0]                     s_axis_tuser,  // [2:0] command
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [0] range_sel, [1] is_far, [4:2] light_level, [16:5] prox_value,
    // [34:17] light_value, [39:35] zero
    output logic [39:0]                    m_axis_tdata,
    output logic [2:0]                     m_axis_tuser   // [2:0] action
);
    import pac_pkg::*;

    t_thr                w_thr;
    logic                w_adv;
    logic                w_fire;
    logic                w_res_valid;
    t_result             w_res;

    logic                r_in_valid;
    logic [2:0]          r_in_cmd;
    logic [SAMPLE_W-1:0] r_in_sample;
    logic                r_out_valid;
    t_result             r_out;

    assign w_adv         = !r_out_valid || m_axis_tready;
    assign w_fire        = r_in_valid && w_adv;
    assign s_axis_tready = !r_in_valid || w_adv;

    pac_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_thr      (w_thr)
    );

    pac_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (w_fire),
        .i_cmd       (r_in_cmd),
        .i_sample    (r_in_sample),
        .i_thr       (w_thr),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (w_adv) begin
                r_out_valid <= r_in_valid && w_res_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_cmd    <= s_axis_tuser;
            r_in_sample <= s_axis_tdata;
        end
        if (w_adv) begin
            r_out <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.action;
    assign m_axis_tdata  = {5'b0, r_out.light_value, r_out.prox_value, r_out.light_level,
                            r_out.is_far, r_out.range_sel};

    // Only measurement requests carry a range selection.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != ACT_MEASURE_IR && m_axis_tuser != ACT_MEASURE_PS
        |-> !r_out.range_sel)
        else $error("range_sel set on a non-measurement result");

    // Light level is only meaningful on a light level result.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != ACT_LIGHT_LEVEL |-> r_out.light_level == '0)
        else $error("stray light level");

    // Light results and light-open acknowledgements carry no prox_value or light_value counts.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == ACT_LIGHT_LEVEL || m_axis_tuser == ACT_LIGHT_INVAL
        || m_axis_tuser == ACT_ACK) |-> r_out.prox_value == '0 && r_out.light_value == '0)
        else $error("counts on a light result");

    // A far report carries no range selection and no light level.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == ACT_REPORT_PROX && r_out.is_far
        |-> !r_out.range_sel && r_out.light_level == '0)
        else $error("malformed far report");

endmodule

// File: tb/tb_proximity_autorange_classifier.sv
// Self-checking testbench for the proximity/light sequencer and classifier.
`timescale 1ns / 1ps
module tb_proximity_autorange_classifier;
    import pac_pkg::*;

    localparam int          CYCLE_LIMIT    = 200000;
    localparam int          PHASE_RESULTS  = 170;
    localparam int          HOLD_CYCLES    = 120;
    localparam int          SETTLE_CYCLES  = 4;
    localparam logic [2:0]  CMD_UNUSED6    = 3'd6;
    localparam logic [2:0]  CMD_UNUSED7    = 3'd7;

    typedef enum logic [1:0] {
        EV_NONE = 2'd0,
        EV_NEAR = 2'd1,
        EV_FAR  = 2'd2
    } t_prox_event;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [15:0] sample;
        logic        typed;
        t_result     want;
    } t_dir_row;

    localparam t_result UNTYPED = '0;

    localparam t_dir_row DIR_ROWS [25] = '{
        '{CMD_LIGHT_OPEN, 16'd0,     1'b1, '{ACT_ACK,         1'b0, 1'b0, 3'd0, 12'd0, 18'd0}},
        '{CMD_ALS,        16'd0,     1'b1, '{ACT_LIGHT_INVAL, 1'b0, 1'b0, 3'd0, 12'd0, 18'd0}},
        '{CMD_ALS,        16'd0,     1'b1, '{ACT_LIGHT_LEVEL, 1'b0, 1'b0, 3'd0, 12'd0, 18'd0}},
        '{CMD_ALS,        16'hFFFF,  1'b1, '{ACT_LIGHT_LEVEL, 1'b0, 1'b0, 3'd6, 12'd0, 18'd0}},
        '{CMD_ALS,        16'd4,     1'b0, UNTYPED},
        '{CMD_ALS,        16'd5,     1'b0, UNTYPED},
        '{CMD_ALS,        16'd1023,  1'b0, UNTYPED},
        '{CMD_ALS,        16'd1024,  1'b0, UNTYPED},
        '{CMD_PROX_OPEN,  16'd0,     1'b1, '{ACT_REPORT_PROX, 1'b0, 1'b1, 3'd0, 12'd0, 18'd0}},
        '{CMD_START,      16'd0,     1'b1, '{ACT_MEASURE_IR,  1'b0, 1'b0, 3'd0, 12'd0, 18'd0}},
        '{CMD_IR,         16'd100,   1'b1, '{ACT_MEASURE_PS,  1'b0, 1'b0, 3'd0, 12'd0, 18'd0}},
        '{CMD_PS,         16'd100,   1'b0, UNTYPED},
        // over the switching limit: go wide once, then no second switch
        '{CMD_IR,         16'd4000,  1'b0, UNTYPED},
        '{CMD_IR,         16'd4000,  1'b0, UNTYPED},
        // first near asks for a new IR sample, the second is reported
        '{CMD_PS,         16'd4030,  1'b0, UNTYPED},
        '{CMD_PS,         16'd4030,  1'b0, UNTYPED},
        '{CMD_START,      16'hFFFF,  1'b0, UNTYPED},
        '{CMD_IR,         16'd0,     1'b0, UNTYPED},
        '{CMD_PS,         16'hFFFF,  1'b0, UNTYPED},
        '{CMD_IR,         16'd5000,  1'b0, UNTYPED},
        // ps below ir is invalid
        '{CMD_PS,         16'd10,    1'b0, UNTYPED},
        '{CMD_UNUSED6,    16'hFFFF,  1'b0, UNTYPED},
        '{CMD_UNUSED7,    16'd0,     1'b0, UNTYPED},
        '{CMD_PS,         16'd0,     1'b0, UNTYPED},
        '{CMD_IR,         16'h8000,  1'b0, UNTYPED}
    };

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CFG_IDX_W-1:0]   i_cfg_idx;
    logic [CFG_DATA_W-1:0]  i_cfg_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [15:0]            s_axis_tdata;   // [15:0] sample
    logic [2:0]             s_axis_tuser;   // [2:0] command
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    // [0] range_sel, [1] is_far, [4:2] light_level, [16:5] prox_value,
    // [34:17] light_value, [39:35] zero
    logic [39:0]            m_axis_tdata;
    logic [2:0]             m_axis_tuser;   // [2:0] action

    proximity_autorange_classifier DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // sequencer state as the block should hold it
    logic          range_wide    = 1'b0;
    logic          adjusted      = 1'b0;
    t_prox_event   last_ev       = EV_NONE;
    logic [11:0]   held_ir       = '0;
    logic          light_pending = 1'b1;
    logic [12:0]   thr [6]       = '{13'd400, 13'd450, 13'd4096, 13'd10, 13'd12, 13'd50};

    t_result       due_responses [$];
    logic [2:0]    last_action;
    int            responses_sent = 0;
    int            responses_seen = 0;
    int            mismatches     = 0;
    int            cycle_count    = 0;
    bit            idle_on        = 1'b1;
    bit            hold_request   = 1'b0;
    bit            hold_taken     = 1'b0;
    int            hold_left      = 0;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic int unsigned sat_sub(input int unsigned a, input int unsigned b);
        return (a > b) ? a - b : 0;
    endfunction

    // Returns 0 when the command produces no transaction on the master side.
    function automatic bit sequence_response(input logic [2:0] cmd, input logic [15:0] raw,
                                             output t_result r);
        logic [11:0]  s;
        int unsigned  hi, lo, err, up, down, d, lvl;
        t_prox_event  ev;
        r   = '0;
        s   = (raw > 16'(CLAMP_MAX)) ? CLAMP_MAX : raw[11:0];
        lo  = range_wide ? thr[REG_LOW_WIDE]  : thr[REG_LOW_NEAR];
        hi  = range_wide ? thr[REG_HIGH_WIDE] : thr[REG_HIGH_NEAR];
        err = range_wide ? thr[REG_ERR_WIDE]  : thr[REG_ERR_NEAR];
        case (cmd)
            CMD_START: begin
                adjusted    = 1'b0;
                r.action    = ACT_MEASURE_IR;
                r.range_sel = range_wide;
            end
            CMD_IR: begin
                up   = sat_sub(sat_sub(ADC_FULL, hi), RANGE_MARGIN);
                down = range_wide ?
                       sat_sub(sat_sub(ADC_FULL, thr[REG_HIGH_NEAR]), GATE_LIMIT) / 4 : 0;
                held_ir  = s;
                r.action = ACT_MEASURE_PS;
                if (s > up) begin
                    if (!adjusted && !range_wide) begin
                        range_wide = 1'b1;
                        adjusted   = 1'b1;
                        r.action   = ACT_MEASURE_IR;
                    end
                end else if (s < down) begin
                    if (!adjusted && range_wide) begin
                        range_wide = 1'b0;
                        adjusted   = 1'b1;
                        r.action   = ACT_MEASURE_IR;
                    end
                end
                r.range_sel = range_wide;
            end
            CMD_PS: begin
                r.prox_value  = s;
                r.light_value = range_wide ? 18'(18'(held_ir) * LIGHT_SCALE) : 18'(held_ir);
                ev = EV_NONE;
                if (s >= held_ir) begin
                    d = s - held_ir;
                    if (d <= err) begin
                        if (d > hi)
                            ev = EV_NEAR;
                        else if (d < lo)
                            ev = EV_FAR;
                    end
                end
                case (ev)
                    EV_FAR: begin
                        last_ev   = EV_FAR;
                        r.action  = ACT_REPORT_PROX;
                        r.is_far  = 1'b1;
                    end
                    EV_NEAR: begin
                        if (last_ev != EV_NEAR) begin
                            last_ev     = EV_NEAR;
                            r.action    = ACT_MEASURE_IR;
                            r.range_sel = range_wide;
                        end else begin
                            r.action = ACT_REPORT_PROX;
                        end
                    end
                    default: begin
                        last_ev  = EV_NONE;
                        r.action = ACT_DONE;
                    end
                endcase
            end
            CMD_ALS: begin
                // table is ascending: level is the number of entries at or below the count
                lvl = 0;
                foreach (LEVEL_TABLE[i])
                    if (s >= LEVEL_TABLE[i])
                        lvl++;
                if (lvl > NUM_LEVELS - 1)
                    lvl = NUM_LEVELS - 1;
                if (light_pending) begin
                    light_pending = 1'b0;
                    r.action      = ACT_LIGHT_INVAL;
                end else begin
                    r.action      = ACT_LIGHT_LEVEL;
                    r.light_level = 3'(lvl);
                end
            end
            CMD_PROX_OPEN: begin
                range_wide = 1'b0;
                adjusted   = 1'b0;
                r.action   = ACT_REPORT_PROX;
                r.is_far   = 1'b1;
            end
            CMD_LIGHT_OPEN: begin
                light_pending = 1'b1;
                r.action      = ACT_ACK;
            end
            default: return 1'b0;
        endcase
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input int unsigned got,
                               input int unsigned want);
        if (got != want)
            report_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
                                      responses_seen, name, got, want));
    endtask

    // Call it right after the clock rises; returns once the block has accepted the transaction.
    task automatic send_item(input logic [2:0] cmd, input logic [15:0] smp);
        t_result r;
        while (idle_on && $urandom_range(99) < 38) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= smp;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        if (sequence_response(cmd, smp, r)) begin
            due_responses.push_back(r);
            responses_sent++;
            last_action = r.action;
        end
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (due_responses.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_thresholds(input logic [12:0] v [6]);
        foreach (v[i]) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= CFG_IDX_W'(i);
            i_cfg_data <= v[i];
            @(posedge i_clk);
            if (i == REG_ERR_NEAR || i == REG_ERR_WIDE)
                thr[i] = v[i];
            else
                thr[i] = {1'b0, v[i][11:0]};
        end
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(9))
            0:       return 16'($urandom_range(65535));
            1:       return 16'h0000;
            2:       return 16'hFFFF;
            3:       return 16'(CLAMP_MAX);
            default: return 16'($urandom_range(4095));
        endcase
    endfunction

    // ps around the held ir so the difference lands near the thresholds
    function automatic logic [15:0] pick_ps();
        int unsigned base;
        base = held_ir;
        case ($urandom_range(5))
            0:       return 16'($urandom_range(65535));
            1:       return 16'(base - $urandom_range(1, 50));
            2, 3:    return 16'(base + $urandom_range(0, 60));
            default: return 16'(base + $urandom_range(0, 700));
        endcase
    endfunction

    task automatic random_burst();
        int unsigned pick;
        int          tries;
        pick = $urandom_range(99);
        if (pick < 65) begin
            send_item(CMD_START, 16'($urandom));
            send_item(CMD_IR, pick_sample());
            if (last_action == ACT_MEASURE_IR)
                send_item(CMD_IR, pick_sample());
            tries = 0;
            do begin
                if ($urandom_range(9) != 0)
                    send_item(CMD_PS, pick_ps());
                tries++;
                // a first near asks for a fresh ir / ps pair
                if (last_action == ACT_MEASURE_IR && tries < 3)
                    send_item(CMD_IR, 16'($urandom_range(held_ir + 20)));
            end while (last_action == ACT_MEASURE_IR && tries < 3);
        end else if (pick < 85) begin
            send_item(CMD_ALS, ($urandom_range(1) != 0) ? 16'($urandom_range(1100))
                                                        : pick_sample());
        end else if (pick < 90) begin
            send_item(CMD_LIGHT_OPEN, 16'($urandom));
        end else if (pick < 94) begin
            send_item(CMD_PROX_OPEN, 16'($urandom));
        end else begin
            send_item(3'($urandom_range(7)), 16'($urandom));
        end
    endtask

    // receiver: random stalls, plus one long hold-off to back the pipe up
    initial begin
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= idle_on ? ($urandom_range(99) >= 38) : 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.action      = m_axis_tuser;
            got.range_sel   = m_axis_tdata[0];
            got.is_far      = m_axis_tdata[1];
            got.light_level = m_axis_tdata[4:2];
            got.prox_value  = m_axis_tdata[16:5];
            got.light_value = m_axis_tdata[34:17];
            if (due_responses.size() == 0) begin
                report_mismatch($sformatf("unexpected transaction, action %0d", got.action));
            end else begin
                want = due_responses.pop_front();
                check_field("action",      got.action,      want.action);
                check_field("range_sel",   got.range_sel,   want.range_sel);
                check_field("is_far",      got.is_far,      want.is_far);
                check_field("light_level", got.light_level, want.light_level);
                check_field("prox_value",  got.prox_value,  want.prox_value);
                check_field("light_value", got.light_value, want.light_value);
            end
            responses_seen++;
        end
    end

    initial begin
        logic [12:0] setting [6];
        int          target;
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= REG_LOW_NEAR;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= CMD_START;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIR_ROWS[k]) begin
            send_item(DIR_ROWS[k].cmd, DIR_ROWS[k].sample);
            if (DIR_ROWS[k].typed)
                due_responses[$] = DIR_ROWS[k].want;
        end

        for (int phase = 0; phase < 5; phase++) begin
            settle();
            idle_on = 1'b1;
            case (phase)
                1: begin
                    setting = '{default: 13'd0};
                    load_thresholds(setting);
                end
                2: begin
                    setting = '{13'd4095, 13'd4095, 13'd4096, 13'd4095, 13'd4095, 13'd4096};
                    load_thresholds(setting);
                end
                3: begin
                    setting[REG_LOW_NEAR]  = 13'($urandom_range(800));
                    setting[REG_HIGH_NEAR] = setting[REG_LOW_NEAR] + 13'($urandom_range(200));
                    setting[REG_ERR_NEAR]  = setting[REG_HIGH_NEAR] + 13'($urandom_range(3000));
                    setting[REG_LOW_WIDE]  = 13'($urandom_range(30));
                    setting[REG_HIGH_WIDE] = setting[REG_LOW_WIDE] + 13'($urandom_range(20));
                    setting[REG_ERR_WIDE]  = setting[REG_HIGH_WIDE] + 13'($urandom_range(80));
                    load_thresholds(setting);
                    idle_on = 1'b0;
                end
                4: begin
                    setting = '{13'(LOW_NEAR_RST), 13'(HIGH_NEAR_RST), ERR_NEAR_RST,
                                13'(LOW_WIDE_RST), 13'(HIGH_WIDE_RST), ERR_WIDE_RST};
                    load_thresholds(setting);
                    hold_request = 1'b1;
                end
                default: ;
            endcase
            target = responses_sent + PHASE_RESULTS;
            while (responses_sent < target)
                random_burst();
        end

        settle();
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
